/* rtl/dts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// shared constants and types for the deadline task scheduler
// ----------------------------------------------------------------------------
package dts_pkg;
   localparam int SLOTS = 8;
   localparam int SW = $clog2(SLOTS + 1);
   localparam int IW = $clog2(SLOTS);
   localparam logic [30:0] NO_VALUE = 31'h7FFFFFFF;
   localparam logic [15:0] STAMP_MAX = 16'hFFFF;

   localparam logic [2:0] ST_FREE  = 3'd0;
   localparam logic [2:0] ST_READY = 3'd1;
   localparam logic [2:0] ST_DONE  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;

   localparam logic [2:0] K_SPAWN  = 3'd0;
   localparam logic [2:0] K_TICK   = 3'd1;
   localparam logic [2:0] K_FINISH = 3'd2;
   localparam logic [2:0] K_LOCK   = 3'd3;
   localparam logic [2:0] K_UNLOCK = 3'd4;
   localparam logic [2:0] K_YIELD  = 3'd5;

   localparam logic [1:0] POL_EDF = 2'd0;
   localparam logic [1:0] POL_RM  = 2'd1;
   localparam logic [1:0] POL_RR  = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] deadline;
      logic [30:0] period;
      logic [30:0] tick_time;
   } req_type;

   typedef struct packed {
      logic [SW-1:0] running_slot;
      logic          switched;
      logic [SW-1:0] new_slot;
      logic          status;
   } rsp_type;
endpackage

/* rtl/dts_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_req_if
// event channel: valid, ready and one event word
// ----------------------------------------------------------------------------
interface dts_req_if import dts_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/dts_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_rsp_if
// result channel: valid, ready and one result word
// ----------------------------------------------------------------------------
interface dts_rsp_if import dts_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/dts_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_cmp
// shared ordering compare: deadline, then period, then entry stamp
// ----------------------------------------------------------------------------
module dts_cmp import dts_pkg::*; (
   input  logic [30:0] a_dl,
   input  logic [30:0] a_per,
   input  logic [15:0] a_stamp,
   input  logic [30:0] b_dl,
   input  logic [30:0] b_per,
   input  logic [15:0] b_stamp,
   output logic        a_first
);
   always_comb begin
      if (a_dl != b_dl) a_first = a_dl < b_dl;
      else if (a_per != b_per) a_first = a_per < b_per;
      else a_first = a_stamp < b_stamp;
   end
endmodule

/* rtl/deadline_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_task_scheduler
// earliest deadline first scheduler over a table of task slots
// ----------------------------------------------------------------------------
// One event is taken at a time; req_ready is low until its result word is
// handed over. Each event runs a small sequencer that walks the slot table one
// slot per cycle through a single ordering comparator. A head search visits
// every slot in S_SCAN and then decides in S_ACT. An event that enters a slot
// into a queue also passes S_ENTER and S_REN. A spawn with no stamp wrap runs
// S_DEC, S_ENTER, S_REN and S_OUT; an event with no work runs S_DEC and S_OUT.
// A tick makes one search per released task plus two more searches, and an
// entry-stamp renumbering on counter wrap makes up to SLOTS+1 searches more.
// Policy codes above two behave as earliest deadline.
module deadline_task_scheduler import dts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dts_req_if.sink   req,
   dts_rsp_if.source rsp,
   input  logic      csr_we,
   input  logic [1:0] csr_wdata
);
   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2, S_ACT = 4'd3,
                          S_ENTER = 4'd4, S_REN = 4'd5, S_OUT = 4'd6;
   // scan purposes
   localparam logic [2:0] P_READY = 3'd0, P_WAIT = 3'd1, P_REL = 3'd2,
                          P_REN = 3'd3, P_TREADY = 3'd4;
   // what follows an entry
   localparam logic [2:0] A_OUT = 3'd0, A_RUNHEAD = 3'd1, A_TICKREL = 3'd2,
                          A_YIELDRUN = 3'd3;

   logic [2:0]  st_ff [SLOTS];
   logic [30:0] dl_ff [SLOTS];
   logic [30:0] per_ff [SLOTS];
   logic [15:0] stm_ff [SLOTS];
   logic [SLOTS-1:0] rdone_ff;
   logic [15:0] cnt_ff;
   logic [SW-1:0] cur_ff, before_ff, best_ff, ent_ff, newslot_ff, hd_ff;
   logic [IW:0] idx_ff;
   logic [1:0]  pol_ff;
   logic        mtx_ff, stat_ff;
   logic [3:0]  state_ff;
   logic [2:0]  purp_ff, after_ff, entst_ff;
   req_type     ev_ff;
   logic        ov_ff;
   rsp_type     od_ff;

   assign req.ready = state_ff == S_IDLE && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.data  = od_ff;

   // candidate test for the slot under the scan index
   logic [IW-1:0] ix;
   logic [IW-1:0] bx;
   logic cand, a_first, better;
   assign ix = idx_ff[IW-1:0];
   assign bx = best_ff[IW-1:0];
   always_comb begin
      case (purp_ff)
         P_READY, P_TREADY: cand = st_ff[ix] == ST_READY;
         P_WAIT: cand = st_ff[ix] == ST_WAIT;
         P_REL: cand = st_ff[ix] == ST_DONE && dl_ff[ix] == ev_ff.tick_time;
         P_REN: cand = (st_ff[ix] == ST_READY || st_ff[ix] == ST_DONE ||
                        st_ff[ix] == ST_WAIT) && !rdone_ff[ix];
         default: cand = 1'b0;
      endcase
   end

   dts_cmp u_cmp (
      .a_dl(purp_ff == P_REN ? 31'd0 : dl_ff[ix]),
      .a_per(purp_ff == P_REN ? 31'd0 : per_ff[ix]),
      .a_stamp(stm_ff[ix]),
      .b_dl(purp_ff == P_REN ? 31'd0 : dl_ff[bx]),
      .b_per(purp_ff == P_REN ? 31'd0 : per_ff[bx]),
      .b_stamp(stm_ff[bx]),
      .a_first(a_first)
   );
   assign better = cand && (best_ff == SW'(SLOTS) || a_first);

   // saturating release deadline
   logic [31:0] sum;
   assign sum = {1'b0, dl_ff[bx]} + {1'b0, per_ff[bx]};

   // lowest free slot
   logic [SW-1:0] free_s;
   always_comb begin
      free_s = SW'(SLOTS);
      for (int i = SLOTS - 1; i >= 0; i--)
         if (st_ff[i] == ST_FREE) free_s = SW'(i);
   end

   logic [IW-1:0] cx, ex;
   assign cx = cur_ff[IW-1:0];
   assign ex = ent_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) st_ff[i] <= ST_FREE;
         cnt_ff <= '0;
         cur_ff <= SW'(SLOTS);
         mtx_ff <= 1'b0;
         pol_ff <= POL_EDF;
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         if (csr_we) pol_ff <= csr_wdata;
         if (ov_ff && rsp.ready) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  ev_ff <= req.data;
                  before_ff <= cur_ff;
                  newslot_ff <= SW'(SLOTS);
                  stat_ff <= 1'b0;
                  state_ff <= S_DEC;
               end
            end
            // decode the event
            S_DEC: begin
               idx_ff <= '0;
               best_ff <= SW'(SLOTS);
               state_ff <= S_OUT;
               case (ev_ff.kind)
                  K_SPAWN: begin
                     if (free_s == SW'(SLOTS)) stat_ff <= 1'b1;
                     else begin
                        dl_ff[free_s[IW-1:0]] <= ev_ff.deadline;
                        per_ff[free_s[IW-1:0]] <= ev_ff.period;
                        newslot_ff <= free_s;
                        ent_ff <= free_s; entst_ff <= ST_READY; after_ff <= A_OUT;
                        state_ff <= S_ENTER;
                     end
                  end
                  K_TICK: begin purp_ff <= P_REL; state_ff <= S_SCAN; end
                  K_FINISH: begin
                     if (cur_ff != SW'(SLOTS)) begin
                        if (per_ff[cx] != NO_VALUE) begin
                           ent_ff <= cur_ff; entst_ff <= ST_DONE; after_ff <= A_RUNHEAD;
                           state_ff <= S_ENTER;
                        end else begin
                           st_ff[cx] <= ST_FREE;
                           purp_ff <= P_READY; state_ff <= S_SCAN;
                        end
                     end
                  end
                  K_LOCK: begin
                     if (cur_ff != SW'(SLOTS)) begin
                        if (!mtx_ff) mtx_ff <= 1'b1;
                        else begin
                           ent_ff <= cur_ff; entst_ff <= ST_WAIT; after_ff <= A_RUNHEAD;
                           state_ff <= S_ENTER;
                        end
                     end
                  end
                  K_UNLOCK: begin purp_ff <= P_WAIT; state_ff <= S_SCAN; end
                  K_YIELD: begin purp_ff <= P_TREADY; state_ff <= S_SCAN; end
                  default: state_ff <= S_OUT;
               endcase
            end
            // one slot per cycle through the comparator
            S_SCAN: begin
               if (better) best_ff <= SW'(idx_ff);
               if (idx_ff == (IW + 1)'(SLOTS - 1)) state_ff <= S_ACT;
               idx_ff <= idx_ff + 1'b1;
            end
            // act on the scan result
            S_ACT: begin
               idx_ff <= '0;
               best_ff <= SW'(SLOTS);
               state_ff <= S_OUT;
               case (purp_ff)
                  P_READY: begin
                     cur_ff <= best_ff;
                     if (best_ff != SW'(SLOTS)) st_ff[bx] <= ST_RUN;
                  end
                  P_WAIT: begin
                     if (best_ff != SW'(SLOTS)) begin
                        ent_ff <= best_ff; entst_ff <= ST_READY; after_ff <= A_OUT;
                        state_ff <= S_ENTER;
                     end else mtx_ff <= 1'b0;
                  end
                  P_REL: begin
                     if (best_ff != SW'(SLOTS)) begin
                        dl_ff[bx] <= sum[31] ? NO_VALUE : sum[30:0];
                        ent_ff <= best_ff; entst_ff <= ST_READY; after_ff <= A_TICKREL;
                        state_ff <= S_ENTER;
                     end else begin
                        // tick preemption decision after releases
                        purp_ff <= (ev_ff.kind == K_TICK) ? P_TREADY : P_READY;
                        state_ff <= S_SCAN;
                     end
                  end
                  P_TREADY: begin
                     hd_ff <= best_ff;
                     if (best_ff == SW'(SLOTS)) state_ff <= S_OUT;
                     else if (cur_ff == SW'(SLOTS)) begin
                        cur_ff <= best_ff; st_ff[bx] <= ST_RUN;
                     end else if (ev_ff.kind == K_YIELD || pol_ff == POL_RR ||
                                  (pol_ff == POL_RM && per_ff[cx] > per_ff[bx]) ||
                                  (pol_ff != POL_RM && pol_ff != POL_RR &&
                                   dl_ff[cx] > dl_ff[bx])) begin
                        ent_ff <= cur_ff; entst_ff <= ST_READY; after_ff <= A_YIELDRUN;
                        state_ff <= S_ENTER;
                     end
                  end
                  P_REN: begin
                     if (best_ff != SW'(SLOTS)) begin
                        rdone_ff[bx] <= 1'b1;
                        stm_ff[bx] <= cnt_ff;
                        cnt_ff <= cnt_ff + 1'b1;
                        purp_ff <= P_REN; state_ff <= S_SCAN;
                     end else state_ff <= S_REN;
                  end
                  default: state_ff <= S_OUT;
               endcase
            end
            // enter a slot into a queue, renumbering on stamp wrap
            S_ENTER: begin
               if (cnt_ff == STAMP_MAX) begin
                  st_ff[ex] <= entst_ff;
                  rdone_ff <= '0;
                  cnt_ff <= '0;
                  idx_ff <= '0;
                  best_ff <= SW'(SLOTS);
                  purp_ff <= P_REN;
                  state_ff <= S_SCAN;
               end else state_ff <= S_REN;
            end
            // stamp the entered slot and continue
            S_REN: begin
               st_ff[ex] <= entst_ff;
               stm_ff[ex] <= cnt_ff;
               cnt_ff <= cnt_ff + 1'b1;
               idx_ff <= '0;
               best_ff <= SW'(SLOTS);
               case (after_ff)
                  A_RUNHEAD: begin purp_ff <= P_READY; state_ff <= S_SCAN; end
                  A_TICKREL: begin purp_ff <= P_REL; state_ff <= S_SCAN; end
                  A_YIELDRUN: begin
                     cur_ff <= hd_ff;
                     st_ff[hd_ff[IW-1:0]] <= ST_RUN;
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_OUT;
               endcase
            end
            // present the result word
            S_OUT: begin
               ov_ff <= 1'b1;
               od_ff.running_slot <= cur_ff;
               od_ff.switched <= cur_ff != before_ff;
               od_ff.new_slot <= newslot_ff;
               od_ff.status <= stat_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the deadline task scheduler
// ----------------------------------------------------------------------------
// A directed table covers the idle cases, a full slot table, spawn extremes,
// the mutex, yield, release on tick and the unused event codes. Random event
// streams follow under every policy setting. Every result word is compared
// with its typed expected word or with a bench-side scheduler that keeps its own slot table.
// ----------------------------------------------------------------------------
module testbench;
   import dts_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [1:0] csr_wdata = 2'd0;

   dts_req_if req ();
   dts_rsp_if rsp ();

   deadline_task_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // bench copy of the slot table
   logic [2:0]  tbl_state [SLOTS];
   logic [30:0] tbl_deadline [SLOTS];
   logic [30:0] tbl_period [SLOTS];
   logic [15:0] tbl_stamp [SLOTS];
   logic [15:0] stamp_count;
   int          running;
   bit          mutex_taken;
   logic [1:0]  policy_now;

   rsp_type pending_words [$];
   int      errors = 0;
   bit      calm = 1'b0;
   logic [30:0] sys_now = 31'd100;

   function automatic bit runs_first(int a, int b);
      if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
      if (tbl_period[a] != tbl_period[b]) return tbl_period[a] < tbl_period[b];
      return tbl_stamp[a] < tbl_stamp[b];
   endfunction

   function automatic int head_in(logic [2:0] s);
      int best;
      best = SLOTS;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_state[i] == s && (best == SLOTS || runs_first(i, best))) best = i;
      return best;
   endfunction

   function automatic bit is_queued(int i);
      return tbl_state[i] == ST_READY || tbl_state[i] == ST_DONE || tbl_state[i] == ST_WAIT;
   endfunction

   // renumber stamps of queued slots from zero, keeping their order
   function automatic void restamp();
      bit          seen [SLOTS];
      logic [15:0] nxt;
      int          best;
      nxt = 16'd0;
      for (int i = 0; i < SLOTS; i++) seen[i] = 1'b0;
      forever begin
         best = SLOTS;
         for (int i = 0; i < SLOTS; i++)
            if (is_queued(i) && !seen[i] &&
                (best == SLOTS || tbl_stamp[i] < tbl_stamp[best])) best = i;
         if (best == SLOTS) break;
         seen[best] = 1'b1;
         tbl_stamp[best] = nxt;
         nxt++;
      end
      stamp_count = nxt;
   endfunction

   function automatic void queue_slot(int s, logic [2:0] st);
      tbl_state[s] = st;
      if (stamp_count == STAMP_MAX) restamp();
      tbl_stamp[s] = stamp_count;
      stamp_count++;
   endfunction

   function automatic void dispatch_head();
      int h;
      h = head_in(ST_READY);
      running = h;
      if (h < SLOTS) tbl_state[h] = ST_RUN;
   endfunction

   function automatic void give_way();
      int h;
      h = head_in(ST_READY);
      if (h == SLOTS) return;
      if (running < SLOTS) queue_slot(running, ST_READY);
      running = h;
      tbl_state[h] = ST_RUN;
   endfunction

   // release done tasks due now, then apply the preemption rule
   function automatic void tick_slots(logic [30:0] now);
      int          best, h;
      logic [31:0] sum;
      forever begin
         best = SLOTS;
         for (int i = 0; i < SLOTS; i++)
            if (tbl_state[i] == ST_DONE && tbl_deadline[i] == now &&
                (best == SLOTS || runs_first(i, best))) best = i;
         if (best == SLOTS) break;
         sum = {1'b0, tbl_deadline[best]} + {1'b0, tbl_period[best]};
         tbl_deadline[best] = (sum > {1'b0, NO_VALUE}) ? NO_VALUE : sum[30:0];
         queue_slot(best, ST_READY);
      end
      h = head_in(ST_READY);
      if (h == SLOTS) return;
      if (running >= SLOTS) begin
         dispatch_head();
      end else if (policy_now == POL_RR) begin
         give_way();
      end else if (policy_now == POL_RM) begin
         if (tbl_period[running] > tbl_period[h]) give_way();
      end else begin
         if (tbl_deadline[running] > tbl_deadline[h]) give_way();
      end
   endfunction

   function automatic rsp_type schedule_event(req_type e);
      rsp_type r;
      int      was, s, w;
      was = running;
      r.new_slot = SW'(SLOTS);
      r.status = 1'b0;
      case (e.kind)
         K_SPAWN: begin
            for (s = 0; s < SLOTS && tbl_state[s] != ST_FREE; s++) ;
            if (s == SLOTS) begin
               r.status = 1'b1;
            end else begin
               tbl_deadline[s] = e.deadline;
               tbl_period[s] = e.period;
               queue_slot(s, ST_READY);
               r.new_slot = SW'(s);
            end
         end
         K_TICK: tick_slots(e.tick_time);
         K_FINISH: begin
            if (running < SLOTS) begin
               if (tbl_period[running] != NO_VALUE) queue_slot(running, ST_DONE);
               else tbl_state[running] = ST_FREE;
               dispatch_head();
            end
         end
         K_LOCK: begin
            if (running < SLOTS) begin
               if (!mutex_taken) begin
                  mutex_taken = 1'b1;
               end else begin
                  queue_slot(running, ST_WAIT);
                  dispatch_head();
               end
            end
         end
         K_UNLOCK: begin
            w = head_in(ST_WAIT);
            if (w < SLOTS) queue_slot(w, ST_READY);
            else mutex_taken = 1'b0;
         end
         K_YIELD: give_way();
         default: ;
      endcase
      r.running_slot = SW'(running);
      r.switched = (running != was);
      return r;
   endfunction

   // directed table: expected word typed in where obvious
   typedef struct {
      req_type e;
      bit      typed;
      rsp_type want;
   } dir_row;

   function automatic dir_row mk(logic [2:0] k, int d, int p,
                                 int t, int ty, int run, int sw, int ns, int st);
      dir_row r;
      r.e.kind = k;
      r.e.deadline = 31'(d);
      r.e.period = 31'(p);
      r.e.tick_time = 31'(t);
      r.typed = (ty != 0);
      r.want.running_slot = SW'(run);
      r.want.switched = (sw != 0);
      r.want.new_slot = SW'(ns);
      r.want.status = (st != 0);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // random event, mostly near the running tick count
   function automatic req_type random_event();
      req_type e;
      int      r, k, c;
      e.deadline = 31'($urandom);
      e.period = 31'($urandom);
      e.tick_time = 31'($urandom);
      r = $urandom_range(0, 99);
      if (r < 25) k = 0; else if (r < 55) k = 1; else if (r < 70) k = 2;
      else if (r < 80) k = 3; else if (r < 90) k = 4; else k = 5;
      e.kind = 3'(k);
      if ($urandom_range(0, 19) != 0) begin
         r = $urandom_range(0, 99);
         if (r < 90) e.deadline = sys_now + 31'($urandom_range(0, 40));
         else if (r < 95) e.deadline = NO_VALUE;
         r = $urandom_range(0, 99);
         if (r < 30) e.period = NO_VALUE;
         else if (r < 35) e.period = 31'd0;
         else e.period = 31'($urandom_range(1, 30));
         r = $urandom_range(0, 99);
         if (r < 45) begin
            sys_now = sys_now + 31'($urandom_range(1, 4));
            e.tick_time = sys_now;
         end else begin
            // aim at a done task's deadline so releases happen
            c = $urandom_range(0, SLOTS - 1);
            e.tick_time = sys_now;
            for (int i = 0; i < SLOTS; i++)
               if (tbl_state[(c + i) % SLOTS] == ST_DONE) begin
                  e.tick_time = tbl_deadline[(c + i) % SLOTS];
                  break;
               end
         end
      end
      return e;
   endfunction

   // hand one event word over and record its expected result
   task automatic send_word(req_type e, bit typed, rsp_type want);
      int      g;
      rsp_type p;
      req.valid <= 1'b1;
      req.data <= e;
      do @(posedge clock); while (!req.ready);
      p = schedule_event(e);
      pending_words.push_back(typed ? want : p);
      g = pick_gap();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_policy(logic [1:0] v);
      wait (pending_words.size() == 0);
      req.valid <= 1'b0;
      repeat (120) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      policy_now = v;
   endtask

   // result side: check and stall
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp.data);
            errors++;
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp.data.running_slot !== exp_w.running_slot) begin
               $display("%0t: running_slot expected %0d actual %0d", $time,
                        exp_w.running_slot, rsp.data.running_slot);
               errors++;
            end
            if (rsp.data.switched !== exp_w.switched) begin
               $display("%0t: switched expected %0d actual %0d", $time,
                        exp_w.switched, rsp.data.switched);
               errors++;
            end
            if (rsp.data.new_slot !== exp_w.new_slot) begin
               $display("%0t: new_slot expected %0d actual %0d", $time,
                        exp_w.new_slot, rsp.data.new_slot);
               errors++;
            end
            if (rsp.data.status !== exp_w.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_w.status, rsp.data.status);
               errors++;
            end
         end
      end
      rsp.ready <= calm ? 1'b1 : (pick_gap() == 0);
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      dir_row  rows [$];
      rsp_type none;
      logic [1:0] pols [6];
      none = '0;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_state[i] = ST_FREE;
         tbl_deadline[i] = '0;
         tbl_period[i] = '0;
         tbl_stamp[i] = '0;
      end
      stamp_count = '0;
      running = SLOTS;
      mutex_taken = 1'b0;
      policy_now = POL_EDF;

      // idle events, full table, extremes, mutex, yield, release, unused codes
      rows.push_back(mk(K_FINISH, 0, 0, 0, 1, SLOTS, 0, SLOTS, 0));
      rows.push_back(mk(K_LOCK, 0, 0, 0, 1, SLOTS, 0, SLOTS, 0));
      rows.push_back(mk(K_UNLOCK, 0, 0, 0, 1, SLOTS, 0, SLOTS, 0));
      rows.push_back(mk(K_YIELD, 0, 0, 0, 1, SLOTS, 0, SLOTS, 0));
      rows.push_back(mk(K_TICK, 0, 0, NO_VALUE, 1, SLOTS, 0, SLOTS, 0));
      rows.push_back(mk(K_SPAWN, 10, 5, 0, 1, SLOTS, 0, 0, 0));
      rows.push_back(mk(K_SPAWN, NO_VALUE, NO_VALUE, 0, 1, SLOTS, 0, 1, 0));
      rows.push_back(mk(K_SPAWN, 0, 0, 0, 1, SLOTS, 0, 2, 0));
      rows.push_back(mk(K_SPAWN, 10, 5, 0, 1, SLOTS, 0, 3, 0));
      rows.push_back(mk(K_SPAWN, 20, NO_VALUE, 0, 1, SLOTS, 0, 4, 0));
      rows.push_back(mk(K_SPAWN, 12, 3, 0, 1, SLOTS, 0, 5, 0));
      rows.push_back(mk(K_SPAWN, 10, 7, 0, 1, SLOTS, 0, 6, 0));
      rows.push_back(mk(K_SPAWN, 1, NO_VALUE - 1, 0, 1, SLOTS, 0, 7, 0));
      rows.push_back(mk(K_SPAWN, 5, 5, 0, 1, SLOTS, 0, SLOTS, 1));
      rows.push_back(mk(K_TICK, 0, 0, 0, 1, 2, 1, SLOTS, 0));
      rows.push_back(mk(K_LOCK, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_FINISH, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_LOCK, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_YIELD, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(K_FINISH, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_word(rows[i].e, rows[i].typed, rows[i].want);

      // random phases under each policy, extremes included
      pols = '{POL_RM, POL_RR, 2'd3, POL_EDF, POL_RR, POL_RM};
      foreach (pols[p]) begin
         write_policy(pols[p]);
         for (int n = 0; n < 115; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            send_word(random_event(), 1'b0, none);
         end
         calm = 1'b0;
      end
      req.valid <= 1'b0;

      wait (pending_words.size() == 0);
      repeat (150) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
